// File: rtl/eaa_pkg.sv
package eaa_pkg;

    typedef enum logic [1:0] {
        MODE_LAYER_START = 2'd0,
        MODE_RECORD      = 2'd1,
        MODE_LAYER_END   = 2'd2,
        MODE_RESET       = 2'd3
    } eaa_mode_t;

    localparam int OP_W      = 3;
    localparam int WEIGHT_W  = 16;
    localparam int LIMIT_W   = 5;
    localparam int COUNT_W   = 32;
    localparam int LAT_W     = 32;
    localparam int ACC_W     = 64;
    localparam int PROD_W    = COUNT_W + WEIGHT_W;
    localparam int CMP_W     = 8;

    localparam logic [OP_W-1:0] OP_INT8_MAC   = 3'd0;
    localparam logic [OP_W-1:0] OP_FP32_MAC   = 3'd1;
    localparam logic [OP_W-1:0] OP_SRAM_READ  = 3'd2;
    localparam logic [OP_W-1:0] OP_SRAM_WRITE = 3'd3;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_INT8_MAC   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_FP32_MAC   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_SRAM_READ  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_SRAM_WRITE = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_LIMIT       = 3'd4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd1;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd16;
    localparam logic [CMP_W-1:0]    LAYER_CEILING = 8'd16;

    localparam int QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 5;
    localparam int M_TDATA_W = 456;
    localparam int M_TUSER_W = 1;

    typedef struct packed {
        logic [WEIGHT_W-1:0] int8_mac;
        logic [WEIGHT_W-1:0] fp32_mac;
        logic [WEIGHT_W-1:0] sram_read;
        logic [WEIGHT_W-1:0] sram_write;
    } eaa_weights_t;

    typedef struct packed {
        eaa_mode_t          mode;
        logic               add_mac;
        logic               add_read;
        logic               add_write;
        logic [COUNT_W-1:0] count;
        logic [PROD_W-1:0]  energy;
        logic [LAT_W-1:0]   latency;
    } eaa_item_t;

    typedef struct packed {
        logic               status;
        logic [LIMIT_W-1:0] layers_closed;
        logic [ACC_W-1:0]   layer_mac_ops;
        logic [ACC_W-1:0]   layer_energy;
        logic [ACC_W-1:0]   sum_mac_ops;
        logic [ACC_W-1:0]   sum_reads;
        logic [ACC_W-1:0]   sum_writes;
        logic [ACC_W-1:0]   sum_energy;
        logic [LAT_W-1:0]   sum_latency;
        logic [LAT_W-1:0]   inference_number;
    } eaa_result_t;

endpackage

// File: rtl/eaa_front.sv
module eaa_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tuser: mode [1:0], op_type [4:2]
    input  logic [eaa_pkg::S_TUSER_W-1:0] s_tuser,
    // s_tdata: count [31:0], layer_latency [63:32]
    input  logic [eaa_pkg::S_TDATA_W-1:0] s_tdata,
    input  eaa_pkg::eaa_weights_t         weights,
    output logic                          out_valid,
    input  logic                          out_ready,
    output eaa_pkg::eaa_item_t            out_item
);
    import eaa_pkg::*;

    logic               front_valid_reg;
    logic               front_valid_next;
    eaa_item_t          front_item_reg;
    eaa_item_t          front_item_next;
    logic               accept;
    logic [OP_W-1:0]    op;
    logic [COUNT_W-1:0] count;
    logic [WEIGHT_W-1:0] weight;

    assign s_tready = !front_valid_reg || out_ready;
    assign accept   = s_tvalid && s_tready;
    assign op       = s_tuser[4:2];
    assign count    = s_tdata[COUNT_W-1:0];

    always_comb begin
        unique case (op)
            OP_INT8_MAC:   weight = weights.int8_mac;
            OP_FP32_MAC:   weight = weights.fp32_mac;
            OP_SRAM_READ:  weight = weights.sram_read;
            OP_SRAM_WRITE: weight = weights.sram_write;
            default:       weight = WEIGHT_RESET;
        endcase
    end

    always_comb begin
        front_item_next.mode      = eaa_mode_t'(s_tuser[1:0]);
        front_item_next.add_mac   = (op == OP_INT8_MAC) || (op == OP_FP32_MAC);
        front_item_next.add_read  = (op == OP_SRAM_READ);
        front_item_next.add_write = (op == OP_SRAM_WRITE);
        front_item_next.count     = count;
        front_item_next.energy    = PROD_W'(count) * PROD_W'(weight);
        front_item_next.latency   = s_tdata[S_TDATA_W-1:COUNT_W];

        front_valid_next = front_valid_reg;
        if (accept) begin
            front_valid_next = 1'b1;
        end else if (out_ready) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        if (accept) begin
            front_item_reg <= front_item_next;
        end
    end

    assign out_valid = front_valid_reg;
    assign out_item  = front_item_reg;

endmodule

// File: rtl/eaa_queue.sv
module eaa_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  eaa_pkg::eaa_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output eaa_pkg::eaa_item_t out_item
);
    import eaa_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    eaa_item_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             push;
    logic             pop;

    assign in_ready  = (fill_reg != FULL_CNT);
    assign out_valid = (fill_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/eaa_back.sv
module eaa_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  eaa_pkg::eaa_item_t          in_item,
    input  logic [eaa_pkg::LIMIT_W-1:0] layer_limit,
    output logic                        m_valid,
    input  logic                        m_ready,
    output eaa_pkg::eaa_result_t        result
);
    import eaa_pkg::*;

    logic [ACC_W-1:0]   layer_mac_reg,    layer_mac_next;
    logic [ACC_W-1:0]   layer_read_reg,   layer_read_next;
    logic [ACC_W-1:0]   layer_write_reg,  layer_write_next;
    logic [ACC_W-1:0]   layer_energy_reg, layer_energy_next;
    logic [ACC_W-1:0]   mac_total_reg,    mac_total_next;
    logic [ACC_W-1:0]   read_total_reg,   read_total_next;
    logic [ACC_W-1:0]   write_total_reg,  write_total_next;
    logic [ACC_W-1:0]   energy_total_reg, energy_total_next;
    logic [LAT_W-1:0]   latency_total_reg, latency_total_next;
    logic [LIMIT_W-1:0] closed_reg,       closed_next;
    logic [LAT_W-1:0]   inference_reg,    inference_next;
    logic               out_valid_reg,    out_valid_next;
    eaa_result_t        result_reg,       result_next;

    logic               pop;
    logic               limit_hit;
    logic               status;
    logic [CMP_W-1:0]   limit_eff;

    assign in_ready  = !out_valid_reg || m_ready;
    assign pop       = in_valid && in_ready;
    assign limit_eff = (CMP_W'(layer_limit) > LAYER_CEILING) ? LAYER_CEILING
                                                              : CMP_W'(layer_limit);
    assign limit_hit = (CMP_W'(closed_reg) >= limit_eff);

    always_comb begin
        layer_mac_next     = layer_mac_reg;
        layer_read_next    = layer_read_reg;
        layer_write_next   = layer_write_reg;
        layer_energy_next  = layer_energy_reg;
        mac_total_next     = mac_total_reg;
        read_total_next    = read_total_reg;
        write_total_next   = write_total_reg;
        energy_total_next  = energy_total_reg;
        latency_total_next = latency_total_reg;
        closed_next        = closed_reg;
        inference_next     = inference_reg;
        status             = 1'b0;

        if (pop) begin
            if (in_item.mode == MODE_RESET) begin
                mac_total_next     = '0;
                read_total_next    = '0;
                write_total_next   = '0;
                energy_total_next  = '0;
                latency_total_next = '0;
                closed_next        = '0;
                inference_next     = inference_reg + 1'b1;
            end else if (limit_hit) begin
                status = 1'b1;
            end else begin
                unique case (in_item.mode)
                    MODE_LAYER_START: begin
                        layer_mac_next    = '0;
                        layer_read_next   = '0;
                        layer_write_next  = '0;
                        layer_energy_next = '0;
                    end
                    MODE_RECORD: begin
                        if (in_item.add_mac) begin
                            layer_mac_next = layer_mac_reg + ACC_W'(in_item.count);
                        end
                        if (in_item.add_read) begin
                            layer_read_next = layer_read_reg + ACC_W'(in_item.count);
                        end
                        if (in_item.add_write) begin
                            layer_write_next = layer_write_reg + ACC_W'(in_item.count);
                        end
                        layer_energy_next = layer_energy_reg + ACC_W'(in_item.energy);
                    end
                    MODE_LAYER_END: begin
                        mac_total_next     = mac_total_reg + layer_mac_reg;
                        read_total_next    = read_total_reg + layer_read_reg;
                        write_total_next   = write_total_reg + layer_write_reg;
                        energy_total_next  = energy_total_reg + layer_energy_reg;
                        latency_total_next = latency_total_reg + in_item.latency;
                        closed_next        = closed_reg + 1'b1;
                        layer_mac_next     = '0;
                        layer_read_next    = '0;
                        layer_write_next   = '0;
                        layer_energy_next  = '0;
                    end
                    default: begin
                        status = 1'b0;
                    end
                endcase
            end
        end

        result_next.status           = status;
        result_next.layers_closed    = closed_next;
        result_next.layer_mac_ops    = layer_mac_next;
        result_next.layer_energy     = layer_energy_next;
        result_next.sum_mac_ops      = mac_total_next;
        result_next.sum_reads        = read_total_next;
        result_next.sum_writes       = write_total_next;
        result_next.sum_energy       = energy_total_next;
        result_next.sum_latency      = latency_total_next;
        result_next.inference_number = inference_next;

        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_mac_reg     <= '0;
            layer_read_reg    <= '0;
            layer_write_reg   <= '0;
            layer_energy_reg  <= '0;
            mac_total_reg     <= '0;
            read_total_reg    <= '0;
            write_total_reg   <= '0;
            energy_total_reg  <= '0;
            latency_total_reg <= '0;
            closed_reg        <= '0;
            inference_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            layer_mac_reg     <= layer_mac_next;
            layer_read_reg    <= layer_read_next;
            layer_write_reg   <= layer_write_next;
            layer_energy_reg  <= layer_energy_next;
            mac_total_reg     <= mac_total_next;
            read_total_reg    <= read_total_next;
            write_total_reg   <= write_total_next;
            energy_total_reg  <= energy_total_next;
            latency_total_reg <= latency_total_next;
            closed_reg        <= closed_next;
            inference_reg     <= inference_next;
            out_valid_reg     <= out_valid_next;
        end
        if (pop) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign result  = result_reg;

    a_reset_clears_count: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && (in_item.mode == MODE_RESET) |=> (closed_reg == '0))
        else $error("closed layer count not cleared by a profile reset");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(closed_reg) <= LAYER_CEILING)
        else $error("closed layer count beyond the layer maximum");

    a_limit_freezes_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && limit_hit && (in_item.mode != MODE_RESET)
        |=> $stable(closed_reg) && $stable(layer_energy_reg) && $stable(mac_total_reg))
        else $error("state changed by a transfer refused at the layer limit");

endmodule

// File: rtl/energy_activity_accumulator_top.sv
// A result reaches the master side from its input transfer through the input register
// with the energy multiplier, the two-entry queue and the result register.
// Throughput: one item per cycle unless the master stalls; all counters update at once.
// Configuration writes are taken in every cycle and act on the next edge.
// Reset (aresetn low, synchronous) clears all counters, sets every weight to one
// and the layer limit to sixteen; no clearing pass is needed.
module energy_activity_accumulator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tuser: mode [1:0], op_type [4:2]
    input  logic [eaa_pkg::S_TUSER_W-1:0]   s_tuser,
    // s_tdata: count [31:0], layer_latency [63:32]
    input  logic [eaa_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tuser: status [0]
    output logic [eaa_pkg::M_TUSER_W-1:0]   m_tuser,
    // m_tdata: layers_closed [4:0], layer_mac_ops [68:5], layer_energy [132:69],
    // sum_mac_ops [196:133], sum_reads [260:197], sum_writes [324:261],
    // sum_energy [388:325], sum_latency [420:389], inference_number [452:421], zero fill
    output logic [eaa_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [eaa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eaa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import eaa_pkg::*;

    eaa_weights_t       weights_reg, weights_next;
    logic [LIMIT_W-1:0] limit_reg,   limit_next;
    logic               cfg_write;

    logic               front_valid;
    logic               front_ready;
    eaa_item_t          front_item;
    logic               queue_valid;
    logic               queue_ready;
    eaa_item_t          queue_item;
    eaa_result_t        result;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        weights_next = weights_reg;
        limit_next   = limit_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_WEIGHT_INT8_MAC:   weights_next.int8_mac   = cfg_data;
                CFG_WEIGHT_FP32_MAC:   weights_next.fp32_mac   = cfg_data;
                CFG_WEIGHT_SRAM_READ:  weights_next.sram_read  = cfg_data;
                CFG_WEIGHT_SRAM_WRITE: weights_next.sram_write = cfg_data;
                CFG_LAYER_LIMIT:       limit_next = cfg_data[LIMIT_W-1:0];
                default:               limit_next = limit_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weights_reg <= '{WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET, WEIGHT_RESET};
            limit_reg   <= LIMIT_RESET;
        end else begin
            weights_reg <= weights_next;
            limit_reg   <= limit_next;
        end
    end

    eaa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .weights   (weights_reg),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    eaa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    eaa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .layer_limit (limit_reg),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .result      (result)
    );

    assign m_tuser = result.status;
    assign m_tdata = {3'b000, result.inference_number, result.sum_latency,
                      result.sum_energy, result.sum_writes, result.sum_reads,
                      result.sum_mac_ops, result.layer_energy, result.layer_mac_ops,
                      result.layers_closed};

endmodule

// File: tb/eaa_profile_checker.sv
module eaa_profile_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [eaa_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic [eaa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [eaa_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic [eaa_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [eaa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eaa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatches,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import eaa_pkg::*;

    logic [WEIGHT_W-1:0] w_int8;
    logic [WEIGHT_W-1:0] w_fp32;
    logic [WEIGHT_W-1:0] w_read;
    logic [WEIGHT_W-1:0] w_write;
    logic [LIMIT_W-1:0]  limit_cfg;

    logic [ACC_W-1:0]   open_mac;
    logic [ACC_W-1:0]   open_read;
    logic [ACC_W-1:0]   open_write;
    logic [ACC_W-1:0]   open_energy;
    logic [ACC_W-1:0]   total_mac;
    logic [ACC_W-1:0]   total_read;
    logic [ACC_W-1:0]   total_write;
    logic [ACC_W-1:0]   total_energy;
    logic [LAT_W-1:0]   total_latency;
    logic [LAT_W-1:0]   inferences;
    logic [LIMIT_W-1:0] layers_done;

    eaa_result_t expected_profiles[$];
    eaa_result_t want;
    eaa_result_t got;

    function automatic void clear_open_layer();
        open_mac    = '0;
        open_read   = '0;
        open_write  = '0;
        open_energy = '0;
    endfunction

    function automatic eaa_result_t predict_profile_step(eaa_mode_t mode, logic [OP_W-1:0] op,
                                                         logic [COUNT_W-1:0] count,
                                                         logic [LAT_W-1:0] latency);
        eaa_result_t r;
        logic [ACC_W-1:0] weight;
        logic [CMP_W-1:0] cap;
        r = '0;
        cap = (CMP_W'(limit_cfg) > LAYER_CEILING) ? LAYER_CEILING : CMP_W'(limit_cfg);
        if (mode == MODE_RESET) begin
            total_mac     = '0;
            total_read    = '0;
            total_write   = '0;
            total_energy  = '0;
            total_latency = '0;
            layers_done   = '0;
            inferences    = inferences + 1'b1;
        end else if (CMP_W'(layers_done) >= cap) begin
            r.status = 1'b1;
        end else if (mode == MODE_LAYER_START) begin
            clear_open_layer();
        end else if (mode == MODE_RECORD) begin
            weight = 64'd1;
            case (op)
                OP_INT8_MAC: begin
                    open_mac = open_mac + ACC_W'(count);
                    weight   = ACC_W'(w_int8);
                end
                OP_FP32_MAC: begin
                    open_mac = open_mac + ACC_W'(count);
                    weight   = ACC_W'(w_fp32);
                end
                OP_SRAM_READ: begin
                    open_read = open_read + ACC_W'(count);
                    weight    = ACC_W'(w_read);
                end
                OP_SRAM_WRITE: begin
                    open_write = open_write + ACC_W'(count);
                    weight     = ACC_W'(w_write);
                end
                default: begin
                end
            endcase
            open_energy = open_energy + ACC_W'(count) * weight;
        end else begin
            total_mac     = total_mac + open_mac;
            total_read    = total_read + open_read;
            total_write   = total_write + open_write;
            total_energy  = total_energy + open_energy;
            total_latency = total_latency + latency;
            layers_done   = layers_done + 1'b1;
            clear_open_layer();
        end
        r.layers_closed    = layers_done;
        r.layer_mac_ops    = open_mac;
        r.layer_energy     = open_energy;
        r.sum_mac_ops      = total_mac;
        r.sum_reads        = total_read;
        r.sum_writes       = total_write;
        r.sum_energy       = total_energy;
        r.sum_latency      = total_latency;
        r.inference_number = inferences;
        return r;
    endfunction

    function automatic eaa_result_t unpack_profile();
        eaa_result_t r;
        r.status           = m_tuser[0];
        r.layers_closed    = m_tdata[4:0];
        r.layer_mac_ops    = m_tdata[68:5];
        r.layer_energy     = m_tdata[132:69];
        r.sum_mac_ops      = m_tdata[196:133];
        r.sum_reads        = m_tdata[260:197];
        r.sum_writes       = m_tdata[324:261];
        r.sum_energy       = m_tdata[388:325];
        r.sum_latency      = m_tdata[420:389];
        r.inference_number = m_tdata[452:421];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
                         expected, actual);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            w_int8        = WEIGHT_RESET;
            w_fp32        = WEIGHT_RESET;
            w_read        = WEIGHT_RESET;
            w_write       = WEIGHT_RESET;
            limit_cfg     = LIMIT_RESET;
            clear_open_layer();
            total_mac     = '0;
            total_read    = '0;
            total_write   = '0;
            total_energy  = '0;
            total_latency = '0;
            inferences    = '0;
            layers_done   = '0;
            mismatches    = 0;
            expected_profiles.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WEIGHT_INT8_MAC:   w_int8    = cfg_data;
                    CFG_WEIGHT_FP32_MAC:   w_fp32    = cfg_data;
                    CFG_WEIGHT_SRAM_READ:  w_read    = cfg_data;
                    CFG_WEIGHT_SRAM_WRITE: w_write   = cfg_data;
                    CFG_LAYER_LIMIT:       limit_cfg = cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            // The result side is checked before the input side so that a result
            // can never be matched against an item accepted in the same cycle.
            if (m_tvalid && m_tready) begin
                got = unpack_profile();
                if (expected_profiles.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing expected", $realtime);
                end else begin
                    want = expected_profiles.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("layers_closed", 64'(want.layers_closed),
                                64'(got.layers_closed));
                    check_field("layer_mac_ops", want.layer_mac_ops, got.layer_mac_ops);
                    check_field("layer_energy", want.layer_energy, got.layer_energy);
                    check_field("sum_mac_ops", want.sum_mac_ops, got.sum_mac_ops);
                    check_field("sum_reads", want.sum_reads, got.sum_reads);
                    check_field("sum_writes", want.sum_writes, got.sum_writes);
                    check_field("sum_energy", want.sum_energy, got.sum_energy);
                    check_field("sum_latency", 64'(want.sum_latency), 64'(got.sum_latency));
                    check_field("inference_number", 64'(want.inference_number),
                                64'(got.inference_number));
                end
            end
            if (s_tvalid && s_tready)
                expected_profiles.push_back(predict_profile_step(eaa_mode_t'(s_tuser[1:0]),
                                                                 s_tuser[4:2], s_tdata[31:0],
                                                                 s_tdata[63:32]));
        end
        pending = expected_profiles.size();
    end

endmodule

// File: tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import eaa_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int mismatches;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    bit long_hold;

    energy_activity_accumulator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    eaa_profile_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("energy_activity_accumulator_top test failed");
        $finish;
    end

    // A requested hold-off keeps the result side stalled for a long stretch.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (64) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic put_item(eaa_mode_t mode, logic [OP_W-1:0] op, logic [COUNT_W-1:0] count,
                            logic [LAT_W-1:0] latency);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {op, mode};
        s_tdata  <= {latency, count};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_settings(logic [WEIGHT_W-1:0] w_int8, logic [WEIGHT_W-1:0] w_fp32,
                                 logic [WEIGHT_W-1:0] w_read, logic [WEIGHT_W-1:0] w_write,
                                 logic [CFG_DATA_W-1:0] limit);
        write_cfg(CFG_WEIGHT_INT8_MAC, w_int8);
        write_cfg(CFG_WEIGHT_FP32_MAC, w_fp32);
        write_cfg(CFG_WEIGHT_SRAM_READ, w_read);
        write_cfg(CFG_WEIGHT_SRAM_WRITE, w_write);
        write_cfg(CFG_LAYER_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(9))
            0, 1, 2: return COUNT_W'($urandom_range(15));
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_inference();
        int layers;
        int records;
        if ($urandom_range(3) == 0)
            put_item(MODE_RESET, OP_W'($urandom_range(7)), $urandom, $urandom);
        layers = $urandom_range(1, 5);
        for (int l = 0; l < layers; l++) begin
            if ($urandom_range(9) != 0)
                put_item(MODE_LAYER_START, OP_W'($urandom_range(7)), $urandom, $urandom);
            records = $urandom_range(0, 4);
            for (int r = 0; r < records; r++)
                put_item(MODE_RECORD, OP_W'($urandom_range(7)), pick_count(), $urandom);
            if ($urandom_range(99) < 12)
                put_item(eaa_mode_t'($urandom_range(3)), OP_W'($urandom_range(7)),
                         pick_count(), $urandom);
            put_item(MODE_LAYER_END, OP_W'($urandom_range(7)), $urandom, $urandom);
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = '0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_WEIGHT_INT8_MAC;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold      = 1'b0;
        items_sent     = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset weights: records before any layer start, every op type at full count,
        // unknown types at one nanojoule, and a wrapping latency sum.
        put_item(MODE_RECORD, OP_INT8_MAC, '1, '0);
        put_item(MODE_RECORD, 3'd4, 32'd5, '1);
        put_item(MODE_LAYER_START, 3'd7, '1, '1);
        for (int op = 0; op < 8; op++)
            put_item(MODE_RECORD, OP_W'(op), '1, '0);
        put_item(MODE_RECORD, OP_SRAM_READ, '0, '1);
        put_item(MODE_LAYER_END, 3'd5, '1, '1);
        put_item(MODE_LAYER_END, OP_INT8_MAC, '0, 32'd2);
        put_item(MODE_RESET, 3'd7, '1, '1);
        settle();

        // Largest weights with a limit of one layer: once it is closed, everything
        // but a profile reset is refused.
        load_settings('1, '1, '1, '1, 16'd1);
        put_item(MODE_LAYER_START, OP_INT8_MAC, '0, '0);
        put_item(MODE_RECORD, OP_FP32_MAC, '1, '0);
        put_item(MODE_LAYER_END, OP_INT8_MAC, '0, 32'd7);
        put_item(MODE_RECORD, OP_INT8_MAC, '1, '0);
        put_item(MODE_LAYER_START, OP_INT8_MAC, '0, '0);
        put_item(MODE_LAYER_END, OP_INT8_MAC, '0, '1);
        put_item(MODE_RESET, OP_INT8_MAC, '0, '0);
        settle();

        // A limit lowered below the layers already closed, then a limit of zero.
        load_settings(16'd3, '0, 16'd2, 16'd1, 16'd16);
        put_item(MODE_LAYER_END, OP_INT8_MAC, '0, 32'd10);
        put_item(MODE_LAYER_END, OP_INT8_MAC, '0, 32'd20);
        put_item(MODE_LAYER_END, OP_INT8_MAC, '0, 32'd30);
        settle();
        load_settings(16'd3, '0, 16'd2, 16'd1, 16'd2);
        put_item(MODE_RECORD, OP_SRAM_WRITE, 32'd9, '0);
        settle();
        load_settings(16'd3, '0, 16'd2, 16'd1, 16'd0);
        put_item(MODE_RESET, OP_INT8_MAC, '0, '0);
        put_item(MODE_LAYER_START, OP_INT8_MAC, '0, '0);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    load_settings(WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                                  WEIGHT_W'($urandom), WEIGHT_W'($urandom), 16'd16);
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                    load_settings('0, '0, '0, '0, 16'd1);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                    load_settings('1, '1, '1, '1, 16'd31);
                end
                default: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                    load_settings(WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                                  WEIGHT_W'($urandom), WEIGHT_W'($urandom),
                                  CFG_DATA_W'($urandom_range(2, 15)));
                end
            endcase
            if (phase == 0) begin
                long_hold = 1'b1;
                for (int k = 0; k < 24; k++)
                    put_item(MODE_RECORD, OP_W'($urandom_range(7)), pick_count(), $urandom);
                settle();
            end
            items_sent = 0;
            while (items_sent < 225)
                run_inference();
            settle();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("energy_activity_accumulator_top test passed");
        end else begin
            $display("energy_activity_accumulator_top test failed");
        end
        $finish;
    end

endmodule
